// ----- rtl/core/barometric_sensor_compensation_core_defines.svh -----
// ---------------------------------------------------------------------------
// Barometric sensor compensation core assertion macros
// Shared assertion forms for the compensation core modules.
// ---------------------------------------------------------------------------
`ifndef BAROMETRIC_SENSOR_COMPENSATION_CORE_DEFINES_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_CORE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define BSCC_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as its antecedent.
`define BSCC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/bscc_pkg.sv -----
// ---------------------------------------------------------------------------
// Barometric sensor compensation package
// Register indexes, compensation constants and shared types.
// ---------------------------------------------------------------------------
package bscc_pkg;

    localparam logic [2:0] REG_TEMP       = 3'd0;
    localparam logic [2:0] REG_PRESS_A    = 3'd1;
    localparam logic [2:0] REG_PRESS_B    = 3'd2;
    localparam logic [2:0] REG_PRESS_NINE = 3'd3;
    localparam logic [2:0] REG_HUM        = 3'd4;
    localparam logic [2:0] REG_HUM_EN     = 3'd5;

    localparam int unsigned C_DIV_STEPS = 64;

    localparam logic signed [33:0] C_P_TFINE_OFS = 34'sd128000;
    localparam logic [31:0]        C_H_TFINE_OFS = 32'd76800;
    localparam logic [20:0]        C_P_BASE      = 21'd1048576;
    localparam logic [11:0]        C_P_SCALE     = 12'd3125;
    localparam logic [63:0]        C_P_ONE47     = 64'h0000_8000_0000_0000;
    localparam logic [31:0]        C_H_ROUND_A   = 32'd16384;
    localparam logic [31:0]        C_H_ADD       = 32'd32768;
    localparam logic [31:0]        C_H_BIAS      = 32'd2097152;
    localparam logic [31:0]        C_H_ROUND_B   = 32'd8192;
    localparam logic [31:0]        C_H_MAX       = 32'd419430400;
    localparam logic [31:0]        C_T_ROUND     = 32'd128;

    typedef struct packed {
        logic [31:0] temp;
        logic [16:0] hum;
        logic        inv;
    } t_div_side;

endpackage

// ----- rtl/core/bscc_div.sv -----
// ---------------------------------------------------------------------------
// Pipelined signed 64-bit divider
// One quotient bit per stage on magnitudes, with the sign applied at the end.
// ---------------------------------------------------------------------------
module bscc_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [63:0]          i_num,
    input  logic [63:0]          i_den,
    input  bscc_pkg::t_div_side  i_side,
    output logic                 o_valid,
    output logic [63:0]          o_quo,
    output bscc_pkg::t_div_side  o_side
);
    import bscc_pkg::*;

    logic        r_vld  [0:C_DIV_STEPS];
    logic [63:0] r_rem  [0:C_DIV_STEPS];
    logic [63:0] r_quo  [0:C_DIV_STEPS];
    logic [63:0] r_den  [0:C_DIV_STEPS];
    logic        r_neg  [0:C_DIV_STEPS];
    t_div_side   r_side [0:C_DIV_STEPS];
    logic        r_out_vld;
    logic [63:0] r_out_quo;
    t_div_side   r_out_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= C_DIV_STEPS; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= C_DIV_STEPS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_vld <= r_vld[C_DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_quo[0]  <= i_num[63] ? (~i_num + 64'd1) : i_num;
            r_den[0]  <= i_den[63] ? (~i_den + 64'd1) : i_den;
            r_neg[0]  <= i_num[63] ^ i_den[63];
            r_side[0] <= i_side;
            r_out_quo  <= r_neg[C_DIV_STEPS] ? (~r_quo[C_DIV_STEPS] + 64'd1)
                                             : r_quo[C_DIV_STEPS];
            r_out_side <= r_side[C_DIV_STEPS];
        end
    end

    for (genvar k = 0; k < C_DIV_STEPS; k++) begin : g_step
        logic [64:0] w_tmp;
        logic [64:0] w_sub;
        logic        w_ge;

        assign w_tmp = {r_rem[k], r_quo[k][63]};
        assign w_sub = w_tmp - {1'b0, r_den[k]};
        assign w_ge  = !w_sub[64];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= w_ge ? w_sub[63:0] : w_tmp[63:0];
                r_quo[k+1]  <= {r_quo[k][62:0], w_ge};
                r_den[k+1]  <= r_den[k];
                r_neg[k+1]  <= r_neg[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_out_vld;
    assign o_quo   = r_out_quo;
    assign o_side  = r_out_side;

endmodule

// ----- rtl/core/barometric_sensor_compensation_core.sv -----
// Throughput: one reading per cycle while the pipeline advances; the 64-stage pressure divider sets the depth.
// The whole pipeline advances whenever the output register is empty or taken.
// Reset (i_rst_n low at a clock edge) clears all valid bits and coefficients.
// ---------------------------------------------------------------------------
// Barometric sensor compensation core
// Integer temperature, pressure and humidity compensation as a deep pipeline.
// ---------------------------------------------------------------------------
`include "barometric_sensor_compensation_core_defines.svh"

module barometric_sensor_compensation_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // adc_temperature[19:0], adc_pressure[39:20], adc_humidity[55:40]
    input  logic [55:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // temperature_centi[31:0], pressure[63:32], humidity_q22_10[80:64]
    output logic [87:0] o_m_axis_tdata,
    // pressure_invalid[0]
    output logic        o_m_axis_tuser
);
    import bscc_pkg::*;

    logic [47:0] r_temp_coeffs;
    logic [63:0] r_press_a;
    logic [63:0] r_press_b;
    logic [15:0] r_press_nine;
    logic [63:0] r_hum_coeffs;
    logic        r_hum_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coeffs <= '0;
            r_press_a     <= '0;
            r_press_b     <= '0;
            r_press_nine  <= '0;
            r_hum_coeffs  <= '0;
            r_hum_en      <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TEMP:       r_temp_coeffs <= i_cfg_data[47:0];
                REG_PRESS_A:    r_press_a     <= i_cfg_data;
                REG_PRESS_B:    r_press_b     <= i_cfg_data;
                REG_PRESS_NINE: r_press_nine  <= i_cfg_data[15:0];
                REG_HUM:        r_hum_coeffs  <= i_cfg_data;
                REG_HUM_EN:     r_hum_en      <= i_cfg_data[0];
                default:        ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    logic [15:0]        w_t1;
    logic signed [15:0] w_t2, w_t3;
    logic [15:0]        w_p1;
    logic signed [15:0] w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;
    logic [7:0]         w_h1, w_h3;
    logic signed [15:0] w_h2;
    logic signed [11:0] w_h4, w_h5;
    logic signed [7:0]  w_h6;

    assign w_t1 = r_temp_coeffs[15:0];
    assign w_t2 = r_temp_coeffs[31:16];
    assign w_t3 = r_temp_coeffs[47:32];
    assign w_p1 = r_press_a[15:0];
    assign w_p2 = r_press_a[31:16];
    assign w_p3 = r_press_a[47:32];
    assign w_p4 = r_press_a[63:48];
    assign w_p5 = r_press_b[15:0];
    assign w_p6 = r_press_b[31:16];
    assign w_p7 = r_press_b[47:32];
    assign w_p8 = r_press_b[63:48];
    assign w_p9 = r_press_nine;
    assign w_h1 = r_hum_coeffs[7:0];
    assign w_h2 = r_hum_coeffs[23:8];
    assign w_h3 = r_hum_coeffs[31:24];
    assign w_h4 = r_hum_coeffs[43:32];
    assign w_h5 = r_hum_coeffs[55:44];
    assign w_h6 = r_hum_coeffs[63:56];

    logic r_out_valid;
    logic w_adv;
    logic r_vld [1:11];

    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    logic [19:0] w_adc_t, w_adc_p;
    logic [15:0] w_adc_h;
    assign w_adc_t = i_s_axis_tdata[19:0];
    assign w_adc_p = i_s_axis_tdata[39:20];
    assign w_adc_h = i_s_axis_tdata[55:40];

    logic [31:0] r_s1_a, r_s1_b;
    logic [19:0] r_adc_p [1:8];
    logic [15:0] r_adc_h [1:5];

    logic signed [47:0] w_s2_at2;
    logic [63:0]        w_s2_bb;
    logic [31:0]        r_s2_v1, r_s2_bb;

    logic signed [31:0] w_s3_bs;
    logic signed [47:0] w_s3_pr;
    logic [31:0]        r_s3_v1, r_s3_v2p;

    logic [31:0] r_s4_tfine;

    logic [31:0]        w_s5_t5;
    logic [31:0]        r_temp [5:11];
    logic signed [33:0] r_s5_w1;
    logic [31:0]        r_s5_xh;

    logic signed [67:0] w_s6_ww;
    logic signed [49:0] w_s6_w1p5, w_s6_w1p2;
    logic [63:0]        r_s6_ww;
    logic signed [49:0] r_s6_w1p5, r_s6_w1p2;
    logic signed [49:0] r_s7_w1p5, r_s7_w1p2;

    logic signed [79:0] w_s7_w2a, w_s7_w1a;
    logic [63:0]        r_s7_w2a, r_s7_w1a;

    logic [63:0] w_s8_w2, w_s8_w1b;
    logic [63:0] r_s8_w2, r_s8_w1b;

    logic [79:0] w_s9_m;
    logic [20:0] w_s9_pp;
    logic [63:0] r_s9_m, r_s9_diff;

    logic [75:0] w_s10_num;
    logic [63:0] r_s10_num, r_s10_den, r_s11_num, r_s11_den;

    logic signed [31:0] w_s6_left;
    logic signed [43:0] w_s6_h5x;
    logic signed [39:0] w_s6_a6;
    logic signed [40:0] w_s6_a3;
    logic [31:0]        r_left [6:8];
    logic [31:0]        r_s6_a6, r_s6_a3;

    logic signed [31:0] w_s7_f1, w_s7_f2;
    logic signed [63:0] w_s7_inner;
    logic [31:0]        r_s7_inner;

    logic signed [31:0] w_s8_t;
    logic signed [47:0] w_s8_th2;
    logic [31:0]        w_s8_rs;
    logic [31:0]        r_s8_right;

    logic [63:0] w_s9_x;
    logic [31:0] r_s9_x;

    logic signed [31:0] w_s10_s;
    logic [63:0]        w_s10_ss;
    logic [31:0]        r_s10_ss, r_s10_x, r_s11_x;

    logic signed [31:0] w_s11_sh;
    logic signed [40:0] w_s11_y;
    logic [31:0]        r_s11_y;

    logic [31:0] w_h_val;
    logic [31:0] w_h_clamp;
    t_div_side   w_div_in_side;

    assign w_s2_at2  = $signed(r_s1_a) * w_t2;
    assign w_s2_bb   = r_s1_b * r_s1_b;
    assign w_s3_bs   = $signed(r_s2_bb) >>> 12;
    assign w_s3_pr   = w_s3_bs * w_t3;
    assign w_s5_t5   = {r_s4_tfine[29:0], 2'b00} + r_s4_tfine + C_T_ROUND;

    assign w_s6_ww   = r_s5_w1 * r_s5_w1;
    assign w_s6_w1p5 = r_s5_w1 * w_p5;
    assign w_s6_w1p2 = r_s5_w1 * w_p2;
    assign w_s7_w2a  = $signed(r_s6_ww) * w_p6;
    assign w_s7_w1a  = $signed(r_s6_ww) * w_p3;
    assign w_s8_w2   = r_s7_w2a + ({{14{r_s7_w1p5[49]}}, r_s7_w1p5} << 17)
                     + ({{48{w_p4[15]}}, w_p4} << 35);
    assign w_s8_w1b  = 64'($signed(r_s7_w1a) >>> 8)
                     + ({{14{r_s7_w1p2[49]}}, r_s7_w1p2} << 12);
    assign w_s9_m    = (C_P_ONE47 + r_s8_w1b) * w_p1;
    assign w_s9_pp   = C_P_BASE - {1'b0, r_adc_p[8]};
    assign w_s10_num = r_s9_diff * C_P_SCALE;

    assign w_s6_h5x  = w_h5 * $signed(r_s5_xh);
    assign w_s6_left = $signed({2'b00, r_adc_h[5], 14'd0}
                     - ({{20{w_h4[11]}}, w_h4} << 20)
                     - w_s6_h5x[31:0] + C_H_ROUND_A) >>> 15;
    assign w_s6_a6   = $signed(r_s5_xh) * w_h6;
    assign w_s6_a3   = $signed(r_s5_xh) * $signed({1'b0, w_h3});
    assign w_s7_f1   = $signed(r_s6_a6) >>> 10;
    assign w_s7_f2   = ($signed(r_s6_a3) >>> 11) + $signed(C_H_ADD);
    assign w_s7_inner = w_s7_f1 * w_s7_f2;
    assign w_s8_t    = ($signed(r_s7_inner) >>> 10) + $signed(C_H_BIAS);
    assign w_s8_th2  = w_s8_t * w_h2;
    assign w_s8_rs   = w_s8_th2[31:0] + C_H_ROUND_B;
    assign w_s9_x    = r_left[8] * r_s8_right;
    assign w_s10_s   = $signed(r_s9_x) >>> 15;
    assign w_s10_ss  = w_s10_s * w_s10_s;
    assign w_s11_sh  = $signed(r_s10_ss) >>> 7;
    assign w_s11_y   = w_s11_sh * $signed({1'b0, w_h1});
    assign w_h_val   = r_s11_x - 32'($signed(r_s11_y) >>> 4);
    assign w_h_clamp = w_h_val[31] ? 32'd0 : ((w_h_val > C_H_MAX) ? C_H_MAX : w_h_val);

    assign w_div_in_side.temp = r_temp[11];
    assign w_div_in_side.hum  = r_hum_en ? w_h_clamp[28:12] : 17'd0;
    assign w_div_in_side.inv  = (r_s11_den == 64'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 11; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[1] <= i_s_axis_tvalid;
            for (int k = 2; k <= 11; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_a     <= {15'd0, w_adc_t[19:3]} - {15'd0, w_t1, 1'b0};
            r_s1_b     <= {16'd0, w_adc_t[19:4]} - {16'd0, w_t1};
            r_adc_p[1] <= w_adc_p;
            r_adc_h[1] <= w_adc_h;
            for (int k = 2; k <= 8; k++) begin
                r_adc_p[k] <= r_adc_p[k-1];
            end
            for (int k = 2; k <= 5; k++) begin
                r_adc_h[k] <= r_adc_h[k-1];
            end

            r_s2_v1    <= 32'($signed(w_s2_at2[31:0]) >>> 11);
            r_s2_bb    <= w_s2_bb[31:0];
            r_s3_v1    <= r_s2_v1;
            r_s3_v2p   <= w_s3_pr[31:0];
            r_s4_tfine <= r_s3_v1 + 32'($signed(r_s3_v2p) >>> 14);

            r_temp[5]  <= 32'($signed(w_s5_t5) >>> 8);
            for (int k = 6; k <= 11; k++) begin
                r_temp[k] <= r_temp[k-1];
            end
            r_s5_w1    <= $signed({{2{r_s4_tfine[31]}}, r_s4_tfine}) - C_P_TFINE_OFS;
            r_s5_xh    <= r_s4_tfine - C_H_TFINE_OFS;

            r_s6_ww    <= w_s6_ww[63:0];
            r_s6_w1p5  <= w_s6_w1p5;
            r_s6_w1p2  <= w_s6_w1p2;
            r_s7_w2a   <= w_s7_w2a[63:0];
            r_s7_w1a   <= w_s7_w1a[63:0];
            r_s7_w1p5  <= r_s6_w1p5;
            r_s7_w1p2  <= r_s6_w1p2;
            r_s8_w2    <= w_s8_w2;
            r_s8_w1b   <= w_s8_w1b;
            r_s9_m     <= w_s9_m[63:0];
            r_s9_diff  <= ({43'd0, w_s9_pp} << 31) - r_s8_w2;
            r_s10_num  <= w_s10_num[63:0];
            r_s10_den  <= 64'($signed(r_s9_m) >>> 33);
            r_s11_num  <= r_s10_num;
            r_s11_den  <= r_s10_den;

            r_left[6]  <= w_s6_left;
            for (int k = 7; k <= 8; k++) begin
                r_left[k] <= r_left[k-1];
            end
            r_s6_a6    <= w_s6_a6[31:0];
            r_s6_a3    <= w_s6_a3[31:0];
            r_s7_inner <= w_s7_inner[31:0];
            r_s8_right <= 32'($signed(w_s8_rs) >>> 14);
            r_s9_x     <= w_s9_x[31:0];
            r_s10_ss   <= w_s10_ss[31:0];
            r_s10_x    <= r_s9_x;
            r_s11_x    <= r_s10_x;
            r_s11_y    <= w_s11_y[31:0];
        end
    end

    logic        w_div_vld;
    logic [63:0] w_div_quo;
    t_div_side   w_div_side;

    bscc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_vld[11]),
        .i_num   (r_s11_num),
        .i_den   (r_s11_den),
        .i_side  (w_div_in_side),
        .o_valid (w_div_vld),
        .o_quo   (w_div_quo),
        .o_side  (w_div_side)
    );

    logic [63:0]        w_q;
    logic [63:0]        w_q1_ll;
    logic [63:0]        w_q1_x;
    logic signed [79:0] w_q1_p8p;
    logic signed [79:0] w_q3_r;
    logic [63:0]        w_q4_sum;
    logic [63:0]        w_q4_res;

    logic        r_q_vld [1:3];
    logic [63:0] r_q_p   [1:3];
    t_div_side   r_q_side [1:3];
    logic [63:0] r_q1_ll, r_q1_p8p, r_q2_p8p, r_q3_p8p;
    logic [31:0] r_q1_x;
    logic [63:0] r_q2_qq, r_q3_r;

    logic        r_out_inv;
    logic [31:0] r_out_temp, r_out_press;
    logic [16:0] r_out_hum;

    assign w_q      = 64'($signed(w_div_quo) >>> 13);
    assign w_q1_ll  = w_q[31:0] * w_q[31:0];
    assign w_q1_x   = w_q[31:0] * w_q[63:32];
    assign w_q1_p8p = $signed(w_div_quo) * w_p8;
    assign w_q3_r   = $signed(r_q2_qq) * w_p9;
    assign w_q4_sum = r_q_p[3] + 64'($signed(r_q3_r) >>> 25)
                    + 64'($signed(r_q3_p8p) >>> 19);
    assign w_q4_res = 64'($signed(w_q4_sum) >>> 8) + ({{48{w_p7[15]}}, w_p7} << 4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld[1]  <= 1'b0;
            r_q_vld[2]  <= 1'b0;
            r_q_vld[3]  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_q_vld[1]  <= w_div_vld;
            r_q_vld[2]  <= r_q_vld[1];
            r_q_vld[3]  <= r_q_vld[2];
            r_out_valid <= r_q_vld[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_q_p[1]    <= w_div_quo;
            r_q_side[1] <= w_div_side;
            r_q1_ll     <= w_q1_ll;
            r_q1_x      <= w_q1_x[31:0];
            r_q1_p8p    <= w_q1_p8p[63:0];

            r_q_p[2]    <= r_q_p[1];
            r_q_side[2] <= r_q_side[1];
            r_q2_qq     <= r_q1_ll + {r_q1_x[30:0], 33'd0};
            r_q2_p8p    <= r_q1_p8p;

            r_q_p[3]    <= r_q_p[2];
            r_q_side[3] <= r_q_side[2];
            r_q3_r      <= w_q3_r[63:0];
            r_q3_p8p    <= r_q2_p8p;

            r_out_temp  <= r_q_side[3].temp;
            r_out_hum   <= r_q_side[3].hum;
            r_out_inv   <= r_q_side[3].inv;
            r_out_press <= r_q_side[3].inv ? 32'd0 : w_q4_res[31:0];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_hum, r_out_press, r_out_temp};
    assign o_m_axis_tuser  = r_out_inv;

    `BSCC_ASSERT_IMP(a_inv_press_zero, r_out_valid && r_out_inv, r_out_press == 32'd0,
        "Pressure is nonzero on a transaction flagged invalid.")
    `BSCC_ASSERT_IMP(a_hum_range, r_out_valid, r_out_hum <= 17'd102400,
        "Humidity result exceeds its clamp limit.")
    `BSCC_ASSERT_IMP(a_hum_disabled, r_out_valid && !r_hum_en, r_out_hum == 17'd0,
        "Humidity result is nonzero while humidity is disabled.")

endmodule

// ----- test/tb_barometric_sensor_compensation_core.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Barometric sensor compensation core testbench
// Drives raw temperature, pressure and humidity readings through the core
// under several calibration settings and random idling on both streams. Each
// result is checked field by field against a behavioral compensation model.
// ---------------------------------------------------------------------------
module tb_barometric_sensor_compensation_core;
    import bscc_pkg::*;

    typedef struct packed {
        logic [15:0] adc_h;
        logic [19:0] adc_p;
        logic [19:0] adc_t;
    } reading_t;

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] press;
        logic [16:0] hum;
        logic        inv;
    } compensated_t;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 100;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [55:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [87:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;

    logic [47:0] cal_temp;
    logic [63:0] cal_press_a;
    logic [63:0] cal_press_b;
    logic [15:0] cal_press_nine;
    logic [63:0] cal_hum;
    logic        cal_hum_en;

    reading_t     pending_readings[$];
    compensated_t expected_results[$];
    int unsigned  sender_idle_pct;
    int unsigned  receiver_idle_pct;
    int unsigned  cycle_count;
    int unsigned  error_count;
    int unsigned  results_checked;
    int unsigned  invalid_seen;
    logic         reading_taken;
    logic         running;

    barometric_sensor_compensation_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic compensated_t compensate(input reading_t rd);
        logic signed [31:0] t1, t2, t3, ta, tb, v1, v2, tfine, tprod;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] w1, w2, pp, q, c1, c2;
        logic signed [31:0] h1, h2, h3, h4, h5, h6, hx, left, inner, right, hs, hv;
        compensated_t res;
        t1 = {16'd0, cal_temp[15:0]};
        t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
        t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
        ta = ({12'd0, rd.adc_t} >> 3) - (t1 <<< 1);
        tprod = ta * t2;
        v1 = tprod >>> 11;
        tb = ({12'd0, rd.adc_t} >> 4) - t1;
        tprod = tb * tb;
        tprod = tprod >>> 12;
        tprod = tprod * t3;
        v2 = tprod >>> 14;
        tfine = v1 + v2;
        tprod = tfine * 5 + 128;
        res.temp = tprod >>> 8;

        p1 = {48'd0, cal_press_a[15:0]};
        p2 = {{48{cal_press_a[31]}}, cal_press_a[31:16]};
        p3 = {{48{cal_press_a[47]}}, cal_press_a[47:32]};
        p4 = {{48{cal_press_a[63]}}, cal_press_a[63:48]};
        p5 = {{48{cal_press_b[15]}}, cal_press_b[15:0]};
        p6 = {{48{cal_press_b[31]}}, cal_press_b[31:16]};
        p7 = {{48{cal_press_b[47]}}, cal_press_b[47:32]};
        p8 = {{48{cal_press_b[63]}}, cal_press_b[63:48]};
        p9 = {{48{cal_press_nine[15]}}, cal_press_nine};
        w1 = {{32{tfine[31]}}, tfine} - 64'sd128000;
        w2 = w1 * w1 * p6;
        w2 = w2 + ((w1 * p5) <<< 17);
        w2 = w2 + (p4 <<< 35);
        w1 = ((w1 * w1 * p3) >>> 8) + ((w1 * p2) <<< 12);
        w1 = ((64'sh0000_8000_0000_0000 + w1) * p1) >>> 33;
        res.press = 32'd0;
        res.inv = 1'b0;
        if (w1 == 64'sd0) begin
            res.inv = 1'b1;
        end else begin
            pp = 64'sd1048576 - {44'd0, rd.adc_p};
            pp = ((pp <<< 31) - w2) * 64'sd3125;
            if (w1 == -64'sd1) begin
                pp = -pp;
            end else begin
                pp = pp / w1;
            end
            q = pp >>> 13;
            c1 = (p9 * q * q) >>> 25;
            c2 = (p8 * pp) >>> 19;
            pp = ((pp + c1 + c2) >>> 8) + (p7 <<< 4);
            res.press = pp[31:0];
        end

        res.hum = 17'd0;
        if (cal_hum_en) begin
            h1 = {24'd0, cal_hum[7:0]};
            h2 = {{16{cal_hum[23]}}, cal_hum[23:8]};
            h3 = {24'd0, cal_hum[31:24]};
            h4 = {{20{cal_hum[43]}}, cal_hum[43:32]};
            h5 = {{20{cal_hum[55]}}, cal_hum[55:44]};
            h6 = {{24{cal_hum[63]}}, cal_hum[63:56]};
            hx = tfine - 32'sd76800;
            left = ({16'd0, rd.adc_h} <<< 14) - (h4 <<< 20) - (h5 * hx) + 32'sd16384;
            left = left >>> 15;
            inner = hx * h6;
            inner = inner >>> 10;
            hs = hx * h3;
            hs = (hs >>> 11) + 32'sd32768;
            inner = inner * hs;
            inner = (inner >>> 10) + 32'sd2097152;
            right = inner * h2 + 32'sd8192;
            right = right >>> 14;
            hv = left * right;
            hs = hv >>> 15;
            hs = hs * hs;
            hs = hs >>> 7;
            hs = hs * h1;
            hv = hv - (hs >>> 4);
            if (hv < 0) hv = 0;
            if (hv > 32'sd419430400) hv = 32'sd419430400;
            res.hum = hv[28:12];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("MISMATCH result %0d %s: got %h expected %h", results_checked, what, got,
                 want);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_TEMP:       cal_temp = val[47:0];
            REG_PRESS_A:    cal_press_a = val;
            REG_PRESS_B:    cal_press_b = val;
            REG_PRESS_NINE: cal_press_nine = val[15:0];
            REG_HUM:        cal_hum = val;
            REG_HUM_EN:     cal_hum_en = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [47:0] tc, input logic [63:0] pa,
                             input logic [63:0] pb, input logic [15:0] p9,
                             input logic [63:0] hc, input logic he);
        cfg_write(REG_TEMP, {16'd0, tc});
        cfg_write(REG_PRESS_A, pa);
        cfg_write(REG_PRESS_B, pb);
        cfg_write(REG_PRESS_NINE, {48'd0, p9});
        cfg_write(REG_HUM, hc);
        cfg_write(REG_HUM_EN, {63'd0, he});
    endtask

    task automatic queue_random(input int unsigned count);
        reading_t rd;
        repeat (count) begin
            if ($urandom_range(1)) begin
                rd.adc_t = 20'($urandom_range(600000, 400000));
                rd.adc_p = 20'($urandom_range(500000, 250000));
            end else begin
                rd.adc_t = 20'($urandom);
                rd.adc_p = 20'($urandom);
            end
            rd.adc_h = 16'($urandom);
            pending_readings.push_back(rd);
        end
    endtask

    task automatic drain;
        do @(posedge i_clk);
        while (pending_readings.size() != 0 || i_s_axis_tvalid ||
               expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_idling(input int unsigned s_pct, input int unsigned r_pct);
        sender_idle_pct = s_pct;
        receiver_idle_pct = r_pct;
    endtask

    always @(negedge i_clk) begin
        if (running) begin
            if (!i_s_axis_tvalid || reading_taken) begin
                if (pending_readings.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct) begin
                    i_s_axis_tdata <= pending_readings.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
            i_m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        compensated_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("barometric_sensor_compensation_core test failed");
            $finish;
        end else if (i_rst_n) begin
            reading_taken = i_s_axis_tvalid && o_s_axis_tready;
            if (reading_taken) begin
                expected_results.push_back(compensate(reading_t'(i_s_axis_tdata)));
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transaction", o_m_axis_tdata[31:0], 32'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_m_axis_tdata[31:0] !== want.temp)
                        report_mismatch("temperature", o_m_axis_tdata[31:0], want.temp);
                    if (o_m_axis_tdata[63:32] !== want.press)
                        report_mismatch("pressure", o_m_axis_tdata[63:32], want.press);
                    if (o_m_axis_tdata[80:64] !== want.hum)
                        report_mismatch("humidity", {15'd0, o_m_axis_tdata[80:64]},
                                        {15'd0, want.hum});
                    if (o_m_axis_tuser !== want.inv)
                        report_mismatch("invalid flag", {31'd0, o_m_axis_tuser},
                                        {31'd0, want.inv});
                    if (want.inv) invalid_seen++;
                    results_checked++;
                end
            end
        end
    end

    initial begin
        reading_t rd;
        cycle_count = 0;
        error_count = 0;
        results_checked = 0;
        invalid_seen = 0;
        reading_taken = 1'b0;
        running = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        cal_temp = '0;
        cal_press_a = '0;
        cal_press_b = '0;
        cal_press_nine = '0;
        cal_hum = '0;
        cal_hum_en = 1'b0;
        set_idling(11, 82);
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        running = 1'b1;

        // All coefficients are zero after reset, so every pressure divisor is zero.
        rd = '0;
        pending_readings.push_back(rd);
        rd = '1;
        pending_readings.push_back(rd);
        queue_random(60);
        drain();

        // Typical calibration with humidity measured.
        write_all({16'hFC18, 16'd26435, 16'd27504},
                  {16'd2855, 16'd3024, 16'hD843, 16'd36477},
                  {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000,
                  {8'd30, 12'd50, 12'd324, 8'd0, 16'd362, 8'd75}, 1'b1);
        rd = '{adc_h: 16'd30000, adc_p: 20'd415148, adc_t: 20'd519888};
        pending_readings.push_back(rd);
        for (int i = 0; i < 4; i++) begin
            rd = '{adc_h: 16'hFFFF >> (i * 4), adc_p: 20'hFFFFF >> (i * 5),
                   adc_t: 20'hFFFFF >> (i * 5)};
            pending_readings.push_back(rd);
        end
        rd = '{adc_h: 16'd0, adc_p: 20'd0, adc_t: 20'd0};
        pending_readings.push_back(rd);
        rd = '{adc_h: 16'hFFFF, adc_p: 20'hFFFFF, adc_t: 20'd0};
        pending_readings.push_back(rd);
        rd = '{adc_h: 16'd0, adc_p: 20'd0, adc_t: 20'hFFFFF};
        pending_readings.push_back(rd);
        rd = '{adc_h: 16'h8000, adc_p: 20'h80000, adc_t: 20'h80000};
        pending_readings.push_back(rd);
        queue_random(400);
        drain();

        set_idling(82, 11);
        write_all(48'($urandom) | (48'($urandom) << 32), {$urandom, $urandom},
                  {$urandom, $urandom}, 16'($urandom), {$urandom, $urandom}, 1'b1);
        queue_random(350);
        drain();

        // Extremes of every coefficient slice.
        write_all('1, '1, '1, 16'h8000, '1, 1'b1);
        queue_random(200);
        drain();

        write_all({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
                  {4{16'h7FFF}}, 16'h7FFF, {8'h7F, 12'h7FF, 12'h7FF, 8'hFF, 16'h7FFF, 8'hFF},
                  1'b1);
        queue_random(200);
        drain();

        set_idling(0, 0);
        write_all({16'h8000, 16'h8000, 16'h0000}, {16'h8000, 16'h8000, 16'h8000, 16'h0001},
                  {4{16'h8000}}, 16'h8000, {8'h80, 12'h800, 12'h800, 8'h00, 16'h8000, 8'h00},
                  1'b0);
        queue_random(150);
        drain();

        write_all(48'($urandom) | (48'($urandom) << 32), {$urandom, $urandom},
                  {$urandom, $urandom}, 16'($urandom), {$urandom, $urandom},
                  1'($urandom));
        queue_random(580);
        drain();

        running = 1'b0;
        $display("Checked %0d results over seven calibration settings, %0d with a zero divisor.",
                 results_checked, invalid_seen);
        if (error_count == 0) begin
            $display("barometric_sensor_compensation_core test passed");
        end else begin
            $display("%0d mismatches found.", error_count);
            $display("barometric_sensor_compensation_core test failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/bscc_pkg.sv
rtl/core/bscc_div.sv
rtl/core/barometric_sensor_compensation_core.sv
test/tb_barometric_sensor_compensation_core.sv
